@@ design/sha512_pkg.sv @@
// Package for the SHA-512 stream hasher: constants, round table and round functions.
package sha512_pkg;

    localparam int WORD_W   = 64;
    localparam int VBYTES_W = 4;
    localparam int INDEX_W  = 3;
    localparam int ROUNDS   = 80;
    localparam int ROUND_W  = 7;
    localparam int LEN_W    = 61;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t PAD_WORD = 64'h8000_0000_0000_0000;

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t r;
        begin
            case (idx)
                3'd0:    r = 64'h6a09e667f3bcc908;
                3'd1:    r = 64'hbb67ae8584caa73b;
                3'd2:    r = 64'h3c6ef372fe94f82b;
                3'd3:    r = 64'ha54ff53a5f1d36f1;
                3'd4:    r = 64'h510e527fade682d1;
                3'd5:    r = 64'h9b05688c2b3e6c1f;
                3'd6:    r = 64'h1f83d9abfb41bd6b;
                default: r = 64'h5be0cd19137e2179;
            endcase
            return r;
        end
    endfunction

    function automatic word_t round_k(input logic [ROUND_W-1:0] idx);
        word_t r;
        begin
            case (idx)
                7'd0:  r = 64'h428a2f98d728ae22; 7'd1:  r = 64'h7137449123ef65cd;
                7'd2:  r = 64'hb5c0fbcfec4d3b2f; 7'd3:  r = 64'he9b5dba58189dbbc;
                7'd4:  r = 64'h3956c25bf348b538; 7'd5:  r = 64'h59f111f1b605d019;
                7'd6:  r = 64'h923f82a4af194f9b; 7'd7:  r = 64'hab1c5ed5da6d8118;
                7'd8:  r = 64'hd807aa98a3030242; 7'd9:  r = 64'h12835b0145706fbe;
                7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
                7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
                7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
                7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
                7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
                7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
                7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
                7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
                7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
                7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
                7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
                7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
                7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
                7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
                7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
                7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
                7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
                7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
                7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
                7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
                7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
                7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
                7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
                7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
                7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
                7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
                7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
                7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
                7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
                7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
                7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
                7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
                7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
                7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
                7'd78: r = 64'h5fcb6fab3ad6faec; 7'd79: r = 64'h6c44198c4a475817;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t sched_lo(input word_t x);
        return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic word_t sched_hi(input word_t x);
        return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    function automatic word_t big_sig0(input word_t x);
        return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic word_t big_sig1(input word_t x);
        return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

endpackage

@@ design/sha512_if.sv @@
// Valid/ready stream interfaces for the hasher's input and digest channels.
interface sha512_in_if;
    import sha512_pkg::*;
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   data_word;
    logic [VBYTES_W-1:0] valid_bytes;
    logic                last;
    modport source (output valid, data_word, valid_bytes, last, input ready);
    modport sink   (input valid, data_word, valid_bytes, last, output ready);
endinterface

interface sha512_out_if;
    import sha512_pkg::*;
    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  digest_word;
    logic [INDEX_W-1:0] word_index;
    logic               last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ design/sha512_stream_hasher_top.sv @@
// SHA-512 stream hasher: one shared round unit under a small sequencer.
// Words are taken only while idle. A non-last word goes into the schedule window;
// the 16th word of a block also runs the 80 rounds and the fold of the working vars
// into the hash, all in the round loop. A last word gets a pad step unless it is a
// full word ending a block, then rounds and fold per compressed block (one or two, a
// second block with its own pad step first), then 8 digest transfers at up to one per cycle.
// Async active-low reset loads the initial hash and clears all counters.
module sha512_stream_hasher_top (
    input logic clk,
    input logic rst_n,
    sha512_in_if.sink    in_ch,
    sha512_out_if.source out_ch
);
    import sha512_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FOLD  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]         state_reg, state_next;
    word_t              hash_reg [8];
    word_t              var_reg  [8];
    word_t              w_reg    [16];   // 16-word sliding schedule window
    logic [3:0]         pos_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [ROUND_W-1:0] round_reg;
    logic               final_reg;       // digest follows this compression
    logic               second_reg;      // one more padding block, holding the length, needed
    logic [INDEX_W-1:0] oidx_reg;

    logic [3:0]         nbytes;
    word_t              keep_mask, last_data, t1, t2, w_new;
    logic               accept;

    assign accept      = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign nbytes      = (in_ch.valid_bytes > 4'd8) ? 4'd8 : in_ch.valid_bytes;
    assign keep_mask   = ~(~64'd0 >> {nbytes, 3'b000});
    assign last_data   = (in_ch.data_word & keep_mask) | (PAD_WORD >> {nbytes, 3'b000});

    // shared round datapath
    assign t1 = var_reg[7] + big_sig1(var_reg[4])
              + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]))
              + round_k(round_reg) + w_reg[0];
    assign t2 = big_sig0(var_reg[0])
              + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                 ^ (var_reg[1] & var_reg[2]));
    assign w_new = w_reg[0] + sched_lo(w_reg[1]) + w_reg[9] + sched_hi(w_reg[14]);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_ch.last)
                    state_next = (nbytes == 4'd8 && pos_reg == 4'd15) ? ST_ROUND : ST_PAD;
                else if (accept && pos_reg == 4'd15)
                    state_next = ST_ROUND;
            end
            ST_PAD:   state_next = ST_ROUND;
            ST_ROUND: if (round_reg == ROUND_W'(ROUNDS - 1)) state_next = ST_FOLD;
            ST_FOLD:
            begin
                if (second_reg)     state_next = ST_PAD;
                else if (final_reg) state_next = ST_OUT;
                else                state_next = ST_IDLE;
            end
            ST_OUT:
                if (out_ch.ready && oidx_reg == 3'd7) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            len_reg    <= '0;
            round_reg  <= '0;
            final_reg  <= 1'b0;
            second_reg <= 1'b0;
            oidx_reg   <= '0;
            for (int i = 0; i < 8; i++) hash_reg[i] <= init_hash(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (!in_ch.last)
                        begin
                            w_reg[pos_reg] <= in_ch.data_word;
                            len_reg <= len_reg + LEN_W'(8);
                            pos_reg <= pos_reg + 4'd1;
                        end
                        else if (nbytes == 4'd8)
                        begin
                            w_reg[pos_reg] <= in_ch.data_word;
                            len_reg <= len_reg + LEN_W'(8);
                            final_reg <= 1'b1;
                            // pad word goes in the next block when this one is full;
                            // pos 1 marks that the pad is still owed there
                            if (pos_reg == 4'd15)
                            begin
                                second_reg <= 1'b1;
                                pos_reg <= 4'd1;
                            end
                            else
                            begin
                                w_reg[pos_reg + 4'd1] <= PAD_WORD;
                                pos_reg <= pos_reg + 4'd2;
                            end
                        end
                        else
                        begin
                            w_reg[pos_reg] <= last_data;
                            len_reg <= len_reg + LEN_W'(nbytes);
                            final_reg <= 1'b1;
                            pos_reg <= pos_reg + 4'd1;
                        end
                        round_reg <= '0;
                        for (int i = 0; i < 8; i++) var_reg[i] <= hash_reg[i];
                    end
                end
                ST_PAD:
                begin
                    // zero-fill; the length goes in word 15 unless word 14 or 15 is taken
                    if (second_reg)
                    begin
                        for (int i = 0; i < 16; i++) w_reg[i] <= '0;
                        w_reg[0] <= (pos_reg == 4'd1) ? PAD_WORD : '0;
                        w_reg[15] <= {len_reg, 3'b000};
                        second_reg <= 1'b0;
                    end
                    else if (pos_reg == 4'd0 || pos_reg == 4'd15)
                    begin
                        // no room for the length: compress this block, length block follows
                        if (pos_reg == 4'd15) w_reg[15] <= '0;
                        second_reg <= 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < 15; i++)
                            if (4'(i) >= pos_reg) w_reg[i] <= '0;
                        w_reg[15] <= {len_reg, 3'b000};
                    end
                    pos_reg <= '0;
                    round_reg <= '0;
                    for (int i = 0; i < 8; i++) var_reg[i] <= hash_reg[i];
                end
                ST_ROUND:
                begin
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i + 1];
                    w_reg[15] <= w_new;
                    var_reg[7] <= var_reg[6];
                    var_reg[6] <= var_reg[5];
                    var_reg[5] <= var_reg[4];
                    var_reg[4] <= var_reg[3] + t1;
                    var_reg[3] <= var_reg[2];
                    var_reg[2] <= var_reg[1];
                    var_reg[1] <= var_reg[0];
                    var_reg[0] <= t1 + t2;
                    round_reg <= round_reg + ROUND_W'(1);
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++) hash_reg[i] <= hash_reg[i] + var_reg[i];
                    oidx_reg <= '0;
                end
                ST_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++) hash_reg[i] <= init_hash(3'(i));
                            len_reg <= '0;
                            pos_reg <= '0;
                            final_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_ch.valid       = (state_reg == ST_OUT);
    assign out_ch.digest_word = hash_reg[oidx_reg];
    assign out_ch.word_index  = oidx_reg;
    assign out_ch.last_word   = (oidx_reg == 3'd7);

    // checks
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid) else $error("ready while emitting digest");
    a_round_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == ROUND_W'(ROUNDS - 1)) |=> state_reg == ST_FOLD)
        else $error("round loop overrun");
    a_out_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> final_reg) else $error("digest without last word");
endmodule

@@ verif/sha512_stream_hasher_top_tb.sv @@
// Self-checking testbench for the SHA-512 stream hasher: random stimulus, digest predictor.
module sha512_stream_hasher_top_tb;
    import sha512_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        word_t                data_word;
        logic [VBYTES_W-1:0]  valid_bytes;
        logic                 last;
    } msg_item_t;

    typedef struct packed {
        word_t               digest_word;
        logic [INDEX_W-1:0]  word_index;
        logic                last_word;
    } digest_item_t;

    logic clk;
    logic rst_n;

    sha512_in_if  in_ch ();
    sha512_out_if out_ch ();

    sha512_stream_hasher_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    localparam word_t K_TAB [0:79] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };
    localparam word_t IV_TAB [0:7] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    // predictor state
    word_t             pm_hash [8];
    word_t             pm_blk [16];
    logic [6:0]        pm_fill;
    logic [LEN_W-1:0]  pm_len;

    msg_item_t    pending_q [$];
    digest_item_t digest_q [$];
    bit           failed;
    int unsigned  cycle_cnt;

    function automatic word_t ror(word_t x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // one 80-round SHA-512 compression of pm_blk into pm_hash
    task automatic compress();
        word_t w [80];
        word_t v [8];
        word_t t1, t2;
        for (int i = 0; i < 16; i++) w[i] = pm_blk[i];
        for (int i = 16; i < 80; i++)
            w[i] = w[i-16] + w[i-7]
                 + (ror(w[i-15], 1) ^ ror(w[i-15], 8) ^ (w[i-15] >> 7))
                 + (ror(w[i-2], 19) ^ ror(w[i-2], 61) ^ (w[i-2] >> 6));
        for (int i = 0; i < 8; i++) v[i] = pm_hash[i];
        for (int i = 0; i < 80; i++) begin
            t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
            t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int j = 7; j > 0; j--) v[j] = v[j-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) pm_hash[i] = pm_hash[i] + v[i];
    endtask

    task automatic hash_reset();
        for (int i = 0; i < 8; i++) pm_hash[i] = IV_TAB[i];
        pm_fill = '0;
        pm_len  = '0;
    endtask

    // fold one accepted word into the running hash, queue digest on last
    task automatic absorb_word(msg_item_t it);
        int pos;
        int nb;
        word_t keep;
        digest_item_t d;
        pos = pm_fill[6:3];
        if (!it.last) begin
            pm_blk[pos] = it.data_word;
            pm_len  = pm_len + 8;
            pm_fill = pm_fill + 8;
            if (pos == 15) compress();
            return;
        end
        nb = (it.valid_bytes > 8) ? 8 : it.valid_bytes;
        pm_len = pm_len + nb;
        if (nb < 8) begin
            keep = (nb == 0) ? '0 : ~64'd0 << (64 - 8 * nb);
            pm_blk[pos] = (it.data_word & keep) | (64'h80 << (56 - 8 * nb));
            pos++;
        end else begin
            pm_blk[pos] = it.data_word;
            pos++;
            if (pos == 16) begin
                compress();
                pos = 0;
            end
            pm_blk[pos] = PAD_WORD;
            pos++;
        end
        if (pos > 14) begin
            for (; pos < 16; pos++) pm_blk[pos] = '0;
            compress();
            pos = 0;
        end
        for (; pos < 15; pos++) pm_blk[pos] = '0;
        pm_blk[15] = {pm_len, 3'b000};
        compress();
        for (int i = 0; i < 8; i++) begin
            d.digest_word = pm_hash[i];
            d.word_index  = i[INDEX_W-1:0];
            d.last_word   = (i == 7);
            digest_q.push_back(d);
        end
        hash_reset();
    endtask

    task automatic add_word(word_t w, int vb, bit lst);
        msg_item_t it;
        it.data_word   = w;
        it.valid_bytes = vb[VBYTES_W-1:0];
        it.last        = lst;
        pending_q.push_back(it);
    endtask

    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    // message of n full words then a last word with vb bytes
    task automatic add_msg(int n, int vb);
        for (int i = 0; i < n; i++) add_word(rand_word(), $urandom_range(0, 15), 1'b0);
        add_word(rand_word(), vb, 1'b1);
    endtask

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // stimulus
    initial begin
        int n;
        hash_reset();
        rst_n = 1'b0;
        // directed: empty, extremes, pad boundaries, saturating count
        add_word('0, 0, 1'b1);
        add_word(~64'd0, 8, 1'b1);
        add_word(~64'd0, 15, 1'b1);
        add_word(64'h0123456789abcdef, 3, 1'b1);
        add_msg(13, 7);
        add_msg(14, 0);
        for (int i = 0; i < 15; i++) add_word(~64'd0, 4, 1'b0);
        add_word('0, 8, 1'b1);
        // random: mostly short messages, a few crossing block bounds
        n = 0;
        while (n < 160) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 33) : $urandom_range(0, 6);
            add_msg(len, $urandom_range(0, 15));
            n += len + 1;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    bit in_idle_free;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_ch.valid       <= 1'b0;
            in_ch.data_word   <= '0;
            in_ch.valid_bytes <= '0;
            in_ch.last        <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                absorb_word(pending_q.pop_front());
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_q.size() > 0 &&
                    (in_idle_free || $urandom_range(0, 99) >= 12)) begin
                    in_ch.valid       <= 1'b1;
                    in_ch.data_word   <= pending_q[0].data_word;
                    in_ch.valid_bytes <= pending_q[0].valid_bytes;
                    in_ch.last        <= pending_q[0].last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall control: one long hold-off, then a stretch with no idling
    int unsigned hold_cnt;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            hold_cnt     <= 0;
            in_idle_free <= 1'b0;
        end else begin
            hold_cnt <= hold_cnt + 1;
            in_idle_free <= (hold_cnt > 3000 && hold_cnt < 6000);
            if (hold_cnt >= 400 && hold_cnt < 1200)
                out_ch.ready <= 1'b0;
            else if (hold_cnt > 3000 && hold_cnt < 6000)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 99) >= 12);
        end
    end

    // monitor
    always @(posedge clk) begin
        digest_item_t exp_d;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest transfer %h idx %0d", $realtime,
                         out_ch.digest_word, out_ch.word_index);
                failed = 1'b1;
            end else begin
                exp_d = digest_q.pop_front();
                if (exp_d.digest_word !== out_ch.digest_word) begin
                    $display("%0t: digest_word exp %h got %h", $realtime,
                             exp_d.digest_word, out_ch.digest_word);
                    failed = 1'b1;
                end
                if (exp_d.word_index !== out_ch.word_index) begin
                    $display("%0t: word_index exp %0d got %0d", $realtime,
                             exp_d.word_index, out_ch.word_index);
                    failed = 1'b1;
                end
                if (exp_d.last_word !== out_ch.last_word) begin
                    $display("%0t: last_word exp %b got %b", $realtime,
                             exp_d.last_word, out_ch.last_word);
                    failed = 1'b1;
                end
            end
        end
    end

    // end of run and timeout
    initial begin
        cycle_cnt = 0;
        failed = 1'b0;
        @(posedge rst_n);
        while ((pending_q.size() > 0 || in_ch.valid || digest_q.size() > 0)
               && cycle_cnt < 400000) begin
            @(posedge clk);
            cycle_cnt++;
        end
        if (cycle_cnt >= 400000) begin
            $display("status: fail");
            $finish;
        end else begin
            repeat (200) @(posedge clk);
            if (!failed && digest_q.size() == 0)
                $display("status: pass");
            else
                $display("status: fail");
            $finish;
        end
    end

endmodule
